### sv/ptach_pkg.sv
// shared types, constants and widths for the period tachometer
`timescale 1ns / 1ps
package ptach_pkg;

    // default width of the microsecond counter
    localparam int TIMER_WIDTH_DEF = 32;

    // field widths
    localparam int PPR_W      = 8;
    localparam int IVL_W      = 24;
    localparam int RPM_W      = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    // microseconds per minute, the dividend of every speed update
    localparam logic [RPM_W-1:0] RPM_NUM = 26'd60000000;

    // divide step counter, one quotient bit per step
    localparam int CNT_W = $clog2(RPM_W);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    // register reset values
    localparam logic [PPR_W-1:0] PPR_RST      = 8'd1;
    localparam logic [IVL_W-1:0] INTERVAL_RST = 24'd500000;
    localparam logic [IVL_W-1:0] TIMEOUT_RST  = 24'd500000;

    // work handed from front to back
    typedef struct packed {
        logic             do_div;   // new period measured, update speed
        logic             big;      // divisor wider than RPM_W bits, speed reads zero
        logic [RPM_W-1:0] divisor;  // period times pulses per revolution
        logic             report;   // report interval elapsed on this beat
        logic             stopped;  // time since last edge beyond timeout
    } tach_cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } back_state_t;

endpackage

### sv/period_tachometer.sv
// Period tachometer top level: speed from edge period, reported every interval.
// Input beats are taken while the command queue has room.
// A beat that measures a period is loaded by the back end, divided bit-serially
// (one quotient bit per cycle) unless flagged big, then emitted if it reports.
// A report beat with no divide passes the queue, BK_IDLE and BK_EMIT to m_tvalid.
// aresetn is synchronous, active low; no clearing pass is needed after it.
`timescale 1ns / 1ps
module period_tachometer #(
    parameter int TIMER_WIDTH = ptach_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ptach_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] edge_req
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ptach_pkg::M_TDATA_W-1:0]  m_tdata,   // [25:0] rpm, [26] stopped
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ptach_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptach_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ptach_pkg::*;

    tach_cmd_t        push_cmd;
    tach_cmd_t        head;
    queue_stat_t      q_stat;
    logic             push;
    logic             pop;
    logic [RPM_W-1:0] m_rpm;
    logic             m_stopped;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // result beat packing
    assign m_tdata = {{(M_TDATA_W - RPM_W - 1){1'b0}}, m_stopped, m_rpm};

    ptach_front #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .edge_req  (s_tdata[0]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    ptach_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    ptach_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_rpm     (m_rpm),
        .m_stopped (m_stopped)
    );

endmodule

### sv/ptach_front.sv
// front end: tick counting, edge and report classification, configuration registers
`timescale 1ns / 1ps
module ptach_front #(
    parameter int TIMER_WIDTH = ptach_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic                             edge_req,
    input  logic                             cfg_valid,
    input  logic [ptach_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptach_pkg::CFG_DATA_W-1:0] cfg_data,
    input  ptach_pkg::queue_stat_t           q_stat,
    output logic                             push,
    output ptach_pkg::tach_cmd_t             push_cmd
);
    import ptach_pkg::*;

    localparam int PROD_W = (TIMER_WIDTH + PPR_W > RPM_W + 1) ? TIMER_WIDTH + PPR_W : RPM_W + 1;
    localparam int CMP_W  = (TIMER_WIDTH > IVL_W) ? TIMER_WIDTH : IVL_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    logic [PPR_W-1:0]       ppr_reg;
    logic [IVL_W-1:0]       interval_reg;
    logic [IVL_W-1:0]       timeout_reg;
    logic [TIMER_WIDTH-1:0] since_edge_reg;
    logic [TIMER_WIDTH-1:0] since_edge_next;
    logic                   edge_seen_reg;
    logic [IVL_W-1:0]       report_count_reg;
    logic [IVL_W-1:0]       report_count_next;

    logic                   accept;
    logic [TIMER_WIDTH-1:0] elapsed;
    logic [PROD_W-1:0]      product;
    logic [IVL_W:0]         count_inc;
    logic                   do_div;
    logic                   report;
    logic                   stopped;

    // room in the queue is all the front needs
    assign s_tready = !q_stat.full;

    // classify the beat
    always_comb begin
        accept            = s_tvalid & s_tready;
        elapsed           = (since_edge_reg == TIMER_MAX) ? since_edge_reg
                                                          : since_edge_reg + 1'b1;
        since_edge_next   = edge_req ? '0 : elapsed;
        product           = PROD_W'(elapsed) * PROD_W'(ppr_reg);
        do_div            = edge_req & edge_seen_reg & (ppr_reg != '0);
        count_inc         = {1'b0, report_count_reg} + 1'b1;
        report            = !(count_inc < {1'b0, interval_reg});
        report_count_next = report ? '0 : count_inc[IVL_W-1:0];
        stopped           = CMP_W'(since_edge_next) > CMP_W'(timeout_reg);

        push_cmd.do_div   = do_div;
        push_cmd.big      = |product[PROD_W-1:RPM_W];
        push_cmd.divisor  = product[RPM_W-1:0];
        push_cmd.report   = report;
        push_cmd.stopped  = stopped;
        push              = accept & (do_div | report);
    end

    // tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_edge_reg   <= '0;
            edge_seen_reg    <= 1'b0;
            report_count_reg <= '0;
        end else if (accept) begin
            since_edge_reg   <= since_edge_next;
            edge_seen_reg    <= edge_seen_reg | edge_req;
            report_count_reg <= report_count_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppr_reg      <= PPR_RST;
            interval_reg <= INTERVAL_RST;
            timeout_reg  <= TIMEOUT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PPR:      ppr_reg      <= cfg_data[PPR_W-1:0];
                CFG_INTERVAL: interval_reg <= cfg_data[IVL_W-1:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_data[IVL_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### sv/ptach_queue.sv
// short command queue between the front and back ends
`timescale 1ns / 1ps
module ptach_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ptach_pkg::tach_cmd_t   push_cmd,
    input  logic                   pop,
    output ptach_pkg::tach_cmd_t   head,
    output ptach_pkg::queue_stat_t q_stat
);
    import ptach_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(QUEUE_DEPTH);

    tach_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == DEPTH_C);
    assign q_stat.empty = (count_reg == '0);

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers wrap naturally, depth is a power of two
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

### sv/ptach_back.sv
// back end: bit-serial speed divide, stall check and result register
`timescale 1ns / 1ps
module ptach_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ptach_pkg::queue_stat_t      q_stat,
    input  ptach_pkg::tach_cmd_t        head,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ptach_pkg::RPM_W-1:0] m_rpm,
    output logic                        m_stopped
);
    import ptach_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;
    tach_cmd_t        cmd_reg;
    logic [RPM_W-1:0] rem_reg;
    logic [RPM_W-1:0] rem_next;
    logic [RPM_W-1:0] quo_reg;
    logic [RPM_W-1:0] quo_next;
    logic [CNT_W-1:0] idx_reg;
    logic [RPM_W-1:0] rpm_value_reg;
    logic             m_tvalid_reg;
    logic [RPM_W-1:0] m_rpm_reg;
    logic             m_stopped_reg;

    logic [RPM_W:0]   shifted;
    logic [RPM_W:0]   trial;
    logic             fits;
    logic             out_free;
    logic             out_load;
    logic [RPM_W-1:0] emit_rpm;

    assign m_tvalid  = m_tvalid_reg;
    assign m_rpm     = m_rpm_reg;
    assign m_stopped = m_stopped_reg;

    // one restoring divide step: bring down the next dividend bit
    always_comb begin
        shifted  = {rem_reg, RPM_NUM[idx_reg]};
        trial    = shifted - {1'b0, cmd_reg.divisor};
        fits     = !trial[RPM_W];
        rem_next = fits ? trial[RPM_W-1:0] : shifted[RPM_W-1:0];
        quo_next = {quo_reg[RPM_W-2:0], fits};
        out_free = !m_tvalid_reg || m_tready;
        emit_rpm = cmd_reg.stopped ? '0 : rpm_value_reg;
    end

    // sequencer next state and strobes
    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    pop = 1'b1;
                    if (head.do_div && !head.big) begin
                        state_next = BK_DIV;
                    end else if (head.report) begin
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_DIV: begin
                if (idx_reg == '0) begin
                    state_next = cmd_reg.report ? BK_EMIT : BK_IDLE;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // control state, speed and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            rpm_value_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop && head.do_div && head.big) begin
                rpm_value_reg <= '0;
            end else if (state_reg == BK_DIV && idx_reg == '0) begin
                rpm_value_reg <= quo_next;
            end else if (out_load) begin
                rpm_value_reg <= emit_rpm;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // divide datapath and result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= head;
            rem_reg <= '0;
            quo_reg <= '0;
            idx_reg <= CNT_W'(RPM_W - 1);
        end else if (state_reg == BK_DIV) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            idx_reg <= idx_reg - 1'b1;
        end
        if (out_load) begin
            m_rpm_reg     <= emit_rpm;
            m_stopped_reg <= cmd_reg.stopped;
        end
    end

endmodule

### sv/ptach_checker.sv
// port-level checks on the tachometer result channel, bound to the top level
`timescale 1ns / 1ps
module ptach_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ptach_pkg::M_TDATA_W-1:0] m_tdata
);
    import ptach_pkg::*;

    // a stalled result beat stays offered
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its data
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // speed never exceeds one period of one microsecond
    a_rpm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[RPM_W-1:0] <= RPM_NUM)
        else $error("rpm above full scale");

    // a stalled shaft always reads zero speed
    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[RPM_W] |-> m_tdata[RPM_W-1:0] == '0)
        else $error("stopped beat with nonzero rpm");

    // no result beat straight after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind period_tachometer ptach_checker u_ptach_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
